FILE: src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg - shared types and constants for quaternion to Euler conversion
// Widths, CORDIC angle table, square root cell state and rounding helpers.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int STAGE_W       = 5;
    localparam int SQRT_CELLS    = 29;
    localparam int SQN_W         = 57;
    localparam int RES_W         = 58;
    localparam int MAG_W         = 28;
    localparam int TERM_W        = 36;
    localparam int VEC_W         = 40;
    localparam int ANG_W         = 26;
    localparam int LATENCY       = 6 + SQRT_CELLS + 1 + CORDIC_STAGES + 1;

    localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd268435456);
    localparam logic signed [ANG_W-1:0]  DEG180  = ANG_W'(32'sd5898240);
    localparam logic signed [15:0]       LIM_FULL = 16'sd23040;
    localparam logic signed [15:0]       LIM_HALF = 16'sd11520;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] ang;
        logic                    zero;
    } vec_t;

    typedef struct packed {
        logic [SQN_W-1:0] n;
        logic [RES_W-1:0] res;
    } sqrt_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] sr;
        logic signed [TERM_W-1:0] cr;
        logic signed [TERM_W-1:0] sy;
        logic signed [TERM_W-1:0] cy;
        logic signed [TERM_W-1:0] sp;
        logic                     sat_pos;
        logic                     sat_neg;
    } terms_t;

    typedef struct packed {
        logic sat_pos;
        logic sat_neg;
    } sat_t;

    // atan(2^-i) in 1/32768 degree
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STAGE_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 26'sd1474560;
            5'd1:  v = 26'sd870484;
            5'd2:  v = 26'sd459940;
            5'd3:  v = 26'sd233473;
            5'd4:  v = 26'sd117189;
            5'd5:  v = 26'sd58652;
            5'd6:  v = 26'sd29333;
            5'd7:  v = 26'sd14667;
            5'd8:  v = 26'sd7334;
            5'd9:  v = 26'sd3667;
            5'd10: v = 26'sd1833;
            5'd11: v = 26'sd917;
            5'd12: v = 26'sd458;
            5'd13: v = 26'sd229;
            5'd14: v = 26'sd115;
            5'd15: v = 26'sd57;
            5'd16: v = 26'sd29;
            5'd17: v = 26'sd14;
            5'd18: v = 26'sd7;
            5'd19: v = 26'sd4;
            5'd20: v = 26'sd2;
            5'd21: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    // quadrant fold for vectoring mode
    function automatic vec_t cordic_pre(input logic signed [VEC_W-1:0] y,
                                        input logic signed [VEC_W-1:0] x);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        if (x < 0)
        begin
            v.x   = -x;
            v.y   = -y;
            v.ang = (y >= 0) ? DEG180 : -DEG180;
        end
        else
        begin
            v.x   = x;
            v.y   = y;
            v.ang = '0;
        end
        return v;
    endfunction

    // round half up to 1/128 degree and clamp
    function automatic logic signed [15:0] to_out(input vec_t v,
                                                  input logic signed [15:0] lim);
        logic signed [ANG_W:0]   a;
        logic signed [ANG_W-8:0] r;
        logic signed [15:0]      o;
        a = v.zero ? '0 : (ANG_W+1)'(v.ang) + (ANG_W+1)'(128);
        r = (ANG_W-7)'(a >>> 8);
        if (r > (ANG_W-7)'(lim))
            o = lim;
        else if (r < -(ANG_W-7)'(lim))
            o = -lim;
        else
            o = 16'(r);
        return o;
    endfunction

endpackage

FILE: src/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell - one digit of a pipelined integer square root
// Settles one result bit per cell; the remainder and root move on each cycle.
// ----------------------------------------------------------------------------
module qte_sqrt_cell
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic [STAGE_W-1:0] k,
    input  sqrt_t              d,
    output sqrt_t              q
);

    logic [5:0]       sh;
    logic [RES_W-1:0] bitv;
    logic [RES_W-1:0] trial;
    sqrt_t            q_next;

    always_comb
    begin
        sh    = 6'd56 - {k, 1'b0};
        bitv  = RES_W'(1) << sh;
        trial = d.res + bitv;
        if ({1'b0, d.n} >= trial)
        begin
            q_next.n   = d.n - trial[SQN_W-1:0];
            q_next.res = (d.res >> 1) + bitv;
        end
        else
        begin
            q_next.n   = d.n;
            q_next.res = d.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        q <= q_next;
    end

endmodule

FILE: src/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell - one vectoring CORDIC micro-rotation
// Rotates toward the x axis by atan(2^-stage) and accumulates the angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic [STAGE_W-1:0] stage,
    input  vec_t               d,
    output vec_t               q
);

    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    logic signed [ANG_W-1:0] ta;
    vec_t                    q_next;

    always_comb
    begin
        xs = d.x >>> stage;
        ys = d.y >>> stage;
        ta = atan_entry(stage);
        q_next.zero = d.zero;
        if (d.y > 0)
        begin
            q_next.x   = d.x + ys;
            q_next.y   = d.y - xs;
            q_next.ang = d.ang + ta;
        end
        else
        begin
            q_next.x   = d.x - ys;
            q_next.y   = d.y + xs;
            q_next.ang = d.ang - ta;
        end
    end

    always_ff @(posedge clk)
    begin
        q <= q_next;
    end

endmodule

FILE: src/quaternion_to_euler_degrees.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees - ZYX Euler angles from a unit quaternion
// Product terms, square root chain, then three CORDIC chains in lockstep.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle.
// The square root chain has 29 cells and each CORDIC chain has 16 cells.
// busy is always low; results appear for one cycle with done, no stall.
// Reset clears all valid flags; in-flight transactions are dropped.
module quaternion_to_euler_degrees
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               done,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic signed [15:0] roll_angle,
    output logic               pitch_saturated
);

    logic                 accept;
    logic [5:0]           vld_reg;
    logic [SQRT_CELLS-1:0] sq_vld_reg;
    logic                 pre_vld_reg;
    logic [CORDIC_STAGES-1:0] cv_vld_reg;
    logic                 done_reg;

    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [31:0] p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;
    terms_t             s2_reg, s3_reg, s4_reg, s5_reg;
    terms_t             s2_next;
    terms_t             s3_next;
    logic [MAG_W-1:0]   mag_reg;
    logic [2*MAG_W-1:0] sq_reg;
    logic [SQN_W-1:0]   rem_reg;
    terms_t             sq_side_reg [SQRT_CELLS];
    sqrt_t              sq_chain [SQRT_CELLS+1];
    vec_t               pre_roll_reg, pre_yaw_reg, pre_pitch_reg;
    sat_t               pre_sat_reg;
    sat_t               cv_sat_reg [CORDIC_STAGES];
    vec_t               roll_chain  [CORDIC_STAGES+1];
    vec_t               yaw_chain   [CORDIC_STAGES+1];
    vec_t               pitch_chain [CORDIC_STAGES+1];
    logic signed [15:0] pitch_full;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] yaw_reg, roll_reg;
    logic               sat_reg;
    logic signed [TERM_W-1:0] sp3;
    logic signed [TERM_W-1:0] mag_full;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            sq_vld_reg  <= '0;
            pre_vld_reg <= 1'b0;
            cv_vld_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[4:0], accept};
            sq_vld_reg  <= {sq_vld_reg[SQRT_CELLS-2:0], vld_reg[5]};
            pre_vld_reg <= sq_vld_reg[SQRT_CELLS-1];
            cv_vld_reg  <= {cv_vld_reg[CORDIC_STAGES-2:0], pre_vld_reg};
            done_reg    <= cv_vld_reg[CORDIC_STAGES-1];
        end
    end

    always_comb
    begin
        s2_next.sr = (TERM_W'(p_wx_reg) + TERM_W'(p_yz_reg)) <<< 1;
        s2_next.cr = ONE_Q28 - ((TERM_W'(p_xx_reg) + TERM_W'(p_yy_reg)) <<< 1);
        s2_next.sp = (TERM_W'(p_wy_reg) - TERM_W'(p_zx_reg)) <<< 1;
        s2_next.sy = (TERM_W'(p_wz_reg) + TERM_W'(p_xy_reg)) <<< 1;
        s2_next.cy = ONE_Q28 - ((TERM_W'(p_yy_reg) + TERM_W'(p_zz_reg)) <<< 1);
        s2_next.sat_pos = 1'b0;
        s2_next.sat_neg = 1'b0;
        sp3      = s2_reg.sp;
        mag_full = (sp3 < 0) ? -sp3 : sp3;
        s3_next         = s2_reg;
        s3_next.sat_pos = (sp3 >= ONE_Q28);
        s3_next.sat_neg = (sp3 <= -ONE_Q28);
    end

    // payload path, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg <= quat_w;
            x_reg <= quat_x;
            y_reg <= quat_y;
            z_reg <= quat_z;
        end
        p_wx_reg <= w_reg * x_reg;
        p_yz_reg <= y_reg * z_reg;
        p_xx_reg <= x_reg * x_reg;
        p_yy_reg <= y_reg * y_reg;
        p_wy_reg <= w_reg * y_reg;
        p_zx_reg <= z_reg * x_reg;
        p_wz_reg <= w_reg * z_reg;
        p_xy_reg <= x_reg * y_reg;
        p_zz_reg <= z_reg * z_reg;
        s2_reg   <= s2_next;

        s3_reg  <= s3_next;
        mag_reg <= mag_full[MAG_W-1:0];

        s4_reg  <= s3_reg;
        sq_reg  <= mag_reg * mag_reg;
        s5_reg  <= s4_reg;
        rem_reg <= (SQN_W'(1) << (2*MAG_W)) - SQN_W'(sq_reg);

        sq_side_reg[0] <= s5_reg;
        for (int i = 1; i < SQRT_CELLS; i++)
            sq_side_reg[i] <= sq_side_reg[i-1];

        pre_roll_reg  <= cordic_pre(VEC_W'(sq_side_reg[SQRT_CELLS-1].sr),
                                    VEC_W'(sq_side_reg[SQRT_CELLS-1].cr));
        pre_yaw_reg   <= cordic_pre(VEC_W'(sq_side_reg[SQRT_CELLS-1].sy),
                                    VEC_W'(sq_side_reg[SQRT_CELLS-1].cy));
        pre_pitch_reg <= cordic_pre(VEC_W'(sq_side_reg[SQRT_CELLS-1].sp),
                                    VEC_W'(sq_chain[SQRT_CELLS].res[MAG_W:0]));
        pre_sat_reg.sat_pos <= sq_side_reg[SQRT_CELLS-1].sat_pos;
        pre_sat_reg.sat_neg <= sq_side_reg[SQRT_CELLS-1].sat_neg;

        cv_sat_reg[0] <= pre_sat_reg;
        for (int i = 1; i < CORDIC_STAGES; i++)
            cv_sat_reg[i] <= cv_sat_reg[i-1];

        pitch_reg <= pitch_full[14:0];
        yaw_reg   <= to_out(yaw_chain[CORDIC_STAGES], LIM_FULL);
        roll_reg  <= to_out(roll_chain[CORDIC_STAGES], LIM_FULL);
        sat_reg   <= cv_sat_reg[CORDIC_STAGES-1].sat_pos
                     || cv_sat_reg[CORDIC_STAGES-1].sat_neg;
    end

    assign sq_chain[0].n   = rem_reg;
    assign sq_chain[0].res = '0;

    genvar g;
    generate
        for (g = 0; g < SQRT_CELLS; g++)
        begin : g_sqrt
            qte_sqrt_cell u_cell (
                .clk (clk),
                .k   (STAGE_W'(g)),
                .d   (sq_chain[g]),
                .q   (sq_chain[g+1])
            );
        end
    endgenerate

    assign roll_chain[0]  = pre_roll_reg;
    assign yaw_chain[0]   = pre_yaw_reg;
    assign pitch_chain[0] = pre_pitch_reg;

    generate
        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_cordic
            qte_cordic_cell u_roll (
                .clk   (clk),
                .stage (STAGE_W'(g)),
                .d     (roll_chain[g]),
                .q     (roll_chain[g+1])
            );
            qte_cordic_cell u_yaw (
                .clk   (clk),
                .stage (STAGE_W'(g)),
                .d     (yaw_chain[g]),
                .q     (yaw_chain[g+1])
            );
            qte_cordic_cell u_pitch (
                .clk   (clk),
                .stage (STAGE_W'(g)),
                .d     (pitch_chain[g]),
                .q     (pitch_chain[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        if (cv_sat_reg[CORDIC_STAGES-1].sat_pos)
            pitch_full = LIM_HALF;
        else if (cv_sat_reg[CORDIC_STAGES-1].sat_neg)
            pitch_full = -LIM_HALF;
        else
            pitch_full = to_out(pitch_chain[CORDIC_STAGES], LIM_HALF);
    end

    assign done            = done_reg;
    assign pitch_angle     = pitch_reg;
    assign yaw_angle       = yaw_reg;
    assign roll_angle      = roll_reg;
    assign pitch_saturated = sat_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("transaction result missing after pipeline latency");

    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pitch_saturated) |-> (pitch_angle == 15'sd11520
                                       || pitch_angle == -15'sd11520))
        else $error("saturated pitch not clamped to 90 degrees");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (yaw_angle <= LIM_FULL && yaw_angle >= -LIM_FULL
                  && roll_angle <= LIM_FULL && roll_angle >= -LIM_FULL))
        else $error("yaw or roll out of range");

endmodule
